### rtl/smpo_pkg.sv
// Package of widths, constants and helpers for the sliding mode position observer.
`timescale 1ns / 1ps
package smpo_pkg;
	localparam int DataWidth = 32;
	localparam int FracBits = 16;
	localparam int DtFrac = 24;
	localparam int GainWidth = 31;
	localparam int DtWidth = 24;
	localparam int NumAxes = 3;
	localparam int RootBits = (DataWidth + FracBits + 1) / 2;
	localparam int RemWidth = RootBits + 2;
	localparam int RadWidth = 2 * RootBits;

	localparam logic [1:0] RegRelay = 2'd0;
	localparam logic [1:0] RegTwist = 2'd1;
	localparam logic [1:0] RegStep = 2'd2;
	localparam logic [DtWidth-1:0] StepReset = DtWidth'(16777);

	localparam logic signed [DataWidth-1:0] SMax = {1'b0, {(DataWidth-1){1'b1}}};
	localparam logic signed [DataWidth-1:0] SMin = {1'b1, {(DataWidth-1){1'b0}}};

	typedef logic signed [DataWidth-1:0] data_t;

	// Request to the shared multiplier: signed operand times unsigned gain, shifted.
	typedef struct packed {
		logic start;
		data_t a;
		logic [GainWidth-1:0] b;
		logic use_dt;
	} mul_req_t;

	typedef struct packed {
		logic done;
		data_t p;
	} mul_rsp_t;

	function automatic data_t sat_add(input data_t a, input data_t b);
		logic signed [DataWidth:0] s;
		s = {a[DataWidth-1], a} + {b[DataWidth-1], b};
		if (s[DataWidth] != s[DataWidth-1]) return s[DataWidth] ? SMin : SMax;
		return s[DataWidth-1:0];
	endfunction

	function automatic data_t sat_sub(input data_t a, input data_t b);
		logic signed [DataWidth:0] s;
		s = {a[DataWidth-1], a} - {b[DataWidth-1], b};
		if (s[DataWidth] != s[DataWidth-1]) return s[DataWidth] ? SMin : SMax;
		return s[DataWidth-1:0];
	endfunction

	// Floor of the mean, using one guard bit so the sum cannot overflow.
	function automatic data_t avg_floor(input data_t a, input data_t b);
		logic signed [DataWidth:0] s;
		s = {a[DataWidth-1], a} + {b[DataWidth-1], b};
		return s[DataWidth:1];
	endfunction
endpackage

### rtl/sliding_mode_position_observer_top.sv
// Top level of the three-axis super-twisting position observer and its sequencer.
//   channel | signals                          | handshake
//   in      | mode, accel_*, meas_*            | in_valid / in_ready
//   out     | acc_est_*, velocity_*, twist_vel_*, pos_out_* | out_valid / out_ready
//   config  | cfg_we, cfg_index, cfg_data      | write on cfg_we, no wait
// For each axis an observer item forms the error, runs the 24-step root unit, makes
// three passes through the shared multiplier and then advances the axis.
// A seed item makes one multiply per axis.
// in_ready is high only when idle and the output register is empty.
// Reset clears control, gains and axis state; out_valid holds until out_ready.
`timescale 1ns / 1ps
module sliding_mode_position_observer_top import smpo_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [GainWidth-1:0] cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 mode,
	input  data_t                accel_x,
	input  data_t                accel_y,
	input  data_t                accel_z,
	input  data_t                meas_x,
	input  data_t                meas_y,
	input  data_t                meas_z,
	output logic                 out_valid,
	input  logic                 out_ready,
	output data_t                acc_est_x,
	output data_t                acc_est_y,
	output data_t                acc_est_z,
	output data_t                velocity_x,
	output data_t                velocity_y,
	output data_t                velocity_z,
	output data_t                twist_vel_x,
	output data_t                twist_vel_y,
	output data_t                twist_vel_z,
	output data_t                pos_out_x,
	output data_t                pos_out_y,
	output data_t                pos_out_z
);
	typedef enum logic [3:0] {
		ST_IDLE, ST_ERR, ST_ROOT, ST_MUL_VEL, ST_WAIT_VEL, ST_MUL_TW, ST_WAIT_TW,
		ST_MUL_POS, ST_WAIT_POS, ST_SEED, ST_WAIT_SEED, ST_NEXT
	} state_t;

	state_t state_q;
	logic [1:0] axis_q;
	logic [GainWidth-1:0] relay_q, twist_q;
	logic [DtWidth-1:0] dt_q;
	logic mode_q, out_valid_q;
	data_t acc_in_q [NumAxes];
	data_t meas_in_q [NumAxes];
	data_t pos_est_q [NumAxes];
	data_t vel_int_q [NumAxes];
	data_t pos_int_q [NumAxes];
	data_t prev_acc_q [NumAxes];
	data_t prev_tv_q [NumAxes];
	data_t acc_o_q [NumAxes];
	data_t vel_o_q [NumAxes];
	data_t tv_o_q [NumAxes];
	data_t pos_o_q [NumAxes];
	data_t err_q, acc_est_q, vel_q, tv_q;

	mul_req_t mreq;
	mul_rsp_t mrsp;
	logic sq_start, sq_done;
	logic [RootBits-1:0] sq_root;
	logic [DataWidth-1:0] err_mag;
	data_t root_s, err_c, acc_c;

	smpo_mul u_mul (.clk(clk), .arst_n(arst_n), .req(mreq), .rsp(mrsp));
	smpo_sqrt u_sqrt (.clk(clk), .arst_n(arst_n), .start(sq_start), .radicand(err_mag),
		.done(sq_done), .root(sq_root));

	// The root unit loads in the same cycle the error is registered.
	assign err_mag = err_c[DataWidth-1] ? DataWidth'(-err_c) : err_c;
	assign root_s = err_q[DataWidth-1] ? data_t'(-DataWidth'(sq_root)) : data_t'(DataWidth'(sq_root));
	assign err_c = sat_sub(meas_in_q[axis_q], pos_est_q[axis_q]);
	assign sq_start = (state_q == ST_ERR);

	always_comb begin
		acc_c = acc_in_q[axis_q];
		if (err_c != '0) begin
			acc_c = err_c[DataWidth-1] ? sat_sub(acc_in_q[axis_q], data_t'({1'b0, relay_q}))
				: sat_add(acc_in_q[axis_q], data_t'({1'b0, relay_q}));
		end
		mreq = '0;
		unique case (state_q)
			ST_MUL_VEL: begin
				mreq.start = 1'b1;
				mreq.a = avg_floor(prev_acc_q[axis_q], acc_est_q);
				mreq.b = GainWidth'(dt_q);
				mreq.use_dt = 1'b1;
			end
			ST_MUL_TW: begin
				mreq.start = 1'b1;
				mreq.a = root_s;
				mreq.b = twist_q;
			end
			ST_MUL_POS: begin
				mreq.start = 1'b1;
				mreq.a = avg_floor(prev_tv_q[axis_q], tv_q);
				mreq.b = GainWidth'(dt_q);
				mreq.use_dt = 1'b1;
			end
			ST_SEED: begin
				mreq.start = 1'b1;
				mreq.a = acc_in_q[axis_q];
				mreq.b = GainWidth'(dt_q);
				mreq.use_dt = 1'b1;
			end
			default: ;
		endcase
	end

	assign in_ready = (state_q == ST_IDLE) && !out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			axis_q <= '0;
			out_valid_q <= 1'b0;
			relay_q <= '0;
			twist_q <= '0;
			dt_q <= StepReset;
			for (int i = 0; i < NumAxes; i++) begin
				pos_est_q[i] <= '0;
				vel_int_q[i] <= '0;
				pos_int_q[i] <= '0;
				prev_acc_q[i] <= '0;
				prev_tv_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					RegRelay: relay_q <= cfg_data;
					RegTwist: twist_q <= cfg_data;
					RegStep: dt_q <= cfg_data[DtWidth-1:0];
					default: ;
				endcase
			end
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid && in_ready) begin
						mode_q <= mode;
						acc_in_q[0] <= accel_x;
						acc_in_q[1] <= accel_y;
						acc_in_q[2] <= accel_z;
						meas_in_q[0] <= meas_x;
						meas_in_q[1] <= meas_y;
						meas_in_q[2] <= meas_z;
						axis_q <= '0;
						state_q <= mode ? ST_SEED : ST_ERR;
					end
				end
				ST_ERR: begin
					err_q <= err_c;
					acc_est_q <= acc_c;
					state_q <= ST_ROOT;
				end
				ST_ROOT: begin
					if (sq_done) state_q <= ST_MUL_VEL;
				end
				ST_MUL_VEL: state_q <= ST_WAIT_VEL;
				ST_WAIT_VEL: begin
					if (mrsp.done) begin
						vel_q <= sat_add(vel_int_q[axis_q], mrsp.p);
						state_q <= ST_MUL_TW;
					end
				end
				ST_MUL_TW: state_q <= ST_WAIT_TW;
				ST_WAIT_TW: begin
					if (mrsp.done) begin
						tv_q <= sat_add(vel_q, mrsp.p);
						state_q <= ST_MUL_POS;
					end
				end
				ST_MUL_POS: state_q <= ST_WAIT_POS;
				ST_WAIT_POS: begin
					if (mrsp.done) begin
						pos_int_q[axis_q] <= sat_add(pos_int_q[axis_q], mrsp.p);
						pos_est_q[axis_q] <= sat_add(pos_int_q[axis_q], mrsp.p);
						pos_o_q[axis_q] <= sat_add(pos_int_q[axis_q], mrsp.p);
						vel_int_q[axis_q] <= vel_q;
						prev_acc_q[axis_q] <= acc_est_q;
						prev_tv_q[axis_q] <= tv_q;
						acc_o_q[axis_q] <= acc_est_q;
						vel_o_q[axis_q] <= vel_q;
						tv_o_q[axis_q] <= tv_q;
						state_q <= ST_NEXT;
					end
				end
				ST_SEED: state_q <= ST_WAIT_SEED;
				ST_WAIT_SEED: begin
					if (mrsp.done) begin
						pos_est_q[axis_q] <= meas_in_q[axis_q];
						vel_int_q[axis_q] <= '0;
						pos_int_q[axis_q] <= '0;
						prev_acc_q[axis_q] <= acc_in_q[axis_q];
						prev_tv_q[axis_q] <= mrsp.p;
						acc_o_q[axis_q] <= acc_in_q[axis_q];
						vel_o_q[axis_q] <= '0;
						tv_o_q[axis_q] <= mrsp.p;
						pos_o_q[axis_q] <= meas_in_q[axis_q];
						state_q <= ST_NEXT;
					end
				end
				ST_NEXT: begin
					if (axis_q == 2'(NumAxes - 1)) begin
						out_valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						axis_q <= axis_q + 1'b1;
						state_q <= mode_q ? ST_SEED : ST_ERR;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign acc_est_x = acc_o_q[0];
	assign acc_est_y = acc_o_q[1];
	assign acc_est_z = acc_o_q[2];
	assign velocity_x = vel_o_q[0];
	assign velocity_y = vel_o_q[1];
	assign velocity_z = vel_o_q[2];
	assign twist_vel_x = tv_o_q[0];
	assign twist_vel_y = tv_o_q[1];
	assign twist_vel_z = tv_o_q[2];
	assign pos_out_x = pos_o_q[0];
	assign pos_out_y = pos_o_q[1];
	assign pos_out_z = pos_o_q[2];
endmodule

### rtl/smpo_mul.sv
// Shared sign-magnitude multiplier with truncating shift and saturation.
`timescale 1ns / 1ps
module smpo_mul import smpo_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  mul_req_t req,
	output mul_rsp_t rsp
);
	localparam int ProdWidth = DataWidth + GainWidth;

	logic [ProdWidth-1:0] prod_q;
	logic neg_q, dt_q, busy_q;
	logic [DataWidth-1:0] mag_a;
	logic [ProdWidth-1:0] shifted;
	logic [DataWidth-1:0] lim, q;
	logic over;

	assign mag_a = req.a[DataWidth-1] ? DataWidth'(-req.a) : req.a;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else begin
			busy_q <= req.start;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			prod_q <= ProdWidth'(mag_a) * ProdWidth'(req.b);
			neg_q <= req.a[DataWidth-1];
			dt_q <= req.use_dt;
		end
	end

	always_comb begin
		shifted = dt_q ? (prod_q >> DtFrac) : (prod_q >> FracBits);
		lim = neg_q ? DataWidth'(SMax) + DataWidth'(1) : DataWidth'(SMax);
		over = (shifted[ProdWidth-1:DataWidth] != '0) || (shifted[DataWidth-1:0] > lim);
		q = over ? lim : shifted[DataWidth-1:0];
		rsp.done = busy_q;
		rsp.p = neg_q ? data_t'(-q) : data_t'(q);
	end
endmodule

### rtl/smpo_sqrt.sv
// Digit-by-digit integer square root of |e| scaled by the fraction bits, one digit a cycle.
`timescale 1ns / 1ps
module smpo_sqrt import smpo_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [DataWidth-1:0]      radicand,
	output logic                      done,
	output logic [RootBits-1:0]       root
);
	localparam int CntWidth = $clog2(RootBits + 1);

	logic [RadWidth-1:0] rad_q;
	logic [RemWidth-1:0] rem_q;
	logic [RootBits-1:0] root_q;
	logic [CntWidth-1:0] cnt_q;
	logic busy_q, done_q;
	logic [RemWidth-1:0] rem_sh, trial;

	assign rem_sh = {rem_q[RemWidth-3:0], rad_q[RadWidth-1 -: 2]};
	assign trial = {root_q, 2'b01};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CntWidth'(RootBits);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CntWidth'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q <= RadWidth'({radicand, {FracBits{1'b0}}});
			rem_q <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q <= {rad_q[RadWidth-3:0], 2'b00};
			if (rem_sh >= trial) begin
				rem_q <= rem_sh - trial;
				root_q <= {root_q[RootBits-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				root_q <= {root_q[RootBits-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign root = root_q;
endmodule

### rtl/smpo_checker.sv
// Port-level checker for the observer top level, bound to it.
`timescale 1ns / 1ps
module smpo_checker import smpo_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input data_t acc_est_x,
	input data_t pos_out_x
);
	// The block never takes an item while a result still waits.
	a_no_accept_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("item accepted while result pending");
	// A result cannot appear in the cycle right after an accept.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !out_valid) else $error("result too early");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid && $stable(acc_est_x) && $stable(pos_out_x))
		else $error("stalled result changed");
	// After a result is taken the block is ready again.
	a_ready_after: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready) |=> in_ready) else $error("not ready after result");
endmodule

bind sliding_mode_position_observer_top smpo_checker u_smpo_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .acc_est_x(acc_est_x),
	.pos_out_x(pos_out_x));
